### rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, character codes, scan mode codes and class functions for
// the lisp token scanner.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam logic [2:0] MODE_SKIP    = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_STRING  = 3'd2;
  localparam logic [2:0] MODE_ESCAPE  = 3'd3;
  localparam logic [2:0] MODE_ATOM    = 3'd4;

  localparam logic [1:0] KIND_SYM = 2'd0;
  localparam logic [1:0] KIND_STR = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;
  localparam logic [1:0] KIND_END = 2'd3;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_N      = 8'h6e;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       has_char;
    logic       token_first;
    logic       token_last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
    logic [2:0] mode_next;
    logic       empty_next;
  } dec_t;

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_NUL;
  endfunction

  function automatic logic ends_atom(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF ||
           c == CH_LPAREN || c == CH_RPAREN || c == CH_SEMI;
  endfunction

  function automatic logic is_single(input logic [7:0] c);
    return c == CH_COMMA || c == CH_LPAREN || c == CH_RPAREN || c == CH_QUOTE ||
           c == CH_BQUOTE || c == CH_AT || c == CH_BSLASH;
  endfunction

  function automatic res_t make_res(input logic [1:0] kind, input logic [7:0] ch,
                                    input logic has, input logic first,
                                    input logic last);
    res_t r;
    r.kind        = kind;
    r.char_out    = ch;
    r.has_char    = has;
    r.token_first = first;
    r.token_last  = last;
    return r;
  endfunction

endpackage

### rtl/lts_if.sv
// ----------------------------------------------------------------------------
// lts_if
// Valid/ready channels: source characters in, token results out.
// ----------------------------------------------------------------------------
interface lts_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] char_in;

  modport source (output valid, output command, output char_in, input ready);
  modport sink (input valid, input command, input char_in, output ready);
endinterface

interface lts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_out;
  logic       has_char;
  logic       token_first;
  logic       token_last;

  modport source (output valid, output kind, output char_out, output has_char,
                  output token_first, output token_last, input ready);
  modport sink (input valid, input kind, input char_out, input has_char,
                input token_first, input token_last, output ready);
endinterface

### rtl/lisp_token_scanner.sv
// ----------------------------------------------------------------------------
// lisp_token_scanner
// Streaming tokenizer for Lisp source text.
//
// chars carries one source byte per request (command 0) or an end-of-source
// mark (command 1). tokens carries results: token bytes with kind, first and
// last marks, string close results, parse errors and end-of-source results.
// A request causes zero, one or two results.
// A result is written into the result queue when its request is taken and is
// presented on tokens from the queue head. Throughput: one request per cycle
// while chars.ready is high; a request that gives two results uses two queue
// slots, so a steady run of those slows the input rate.
// Results wait in a four-entry queue; chars.ready is high while the queue
// has room for two results, so a stalled receiver backs up into chars once
// more than two results are queued.
// Reset (rst, synchronous) empties the queue and returns the scanner to
// whitespace skipping with no string open.
// ----------------------------------------------------------------------------
module lisp_token_scanner (
  input logic      clk,
  input logic      rst,
  lts_in_if.sink   chars,
  lts_out_if.source tokens
);

  lts_pkg::dec_t dec;
  lts_pkg::res_t head;
  logic          take;
  logic          room2;
  logic          out_valid;
  logic [1:0]    push_count;

  assign chars.ready = room2;
  assign take        = chars.valid && room2;
  assign push_count  = take ? dec.count : 2'd0;

  lts_scanner_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .command (chars.command),
    .char_in (chars.char_in),
    .dec     (dec)
  );

  lts_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (dec.res0),
    .push1      (dec.res1),
    .room2      (room2),
    .valid      (out_valid),
    .ready      (tokens.ready),
    .head       (head)
  );

  assign tokens.valid       = out_valid;
  assign tokens.kind        = head.kind;
  assign tokens.char_out    = head.char_out;
  assign tokens.has_char    = head.has_char;
  assign tokens.token_first = head.token_first;
  assign tokens.token_last  = head.token_last;

endmodule

### rtl/lts_decode.sv
// ----------------------------------------------------------------------------
// lts_decode
// Scan step for one request: results (up to two) and next scan state.
// ----------------------------------------------------------------------------
module lts_decode (
  input  logic          [2:0] mode,
  input  logic                string_empty,
  input  logic                command,
  input  logic          [7:0] char_in,
  output lts_pkg::dec_t       dec
);

  logic [2:0]    mode_eff;
  lts_pkg::res_t skip_res;
  logic          skip_emit;
  logic [2:0]    skip_mode;
  logic          skip_empty;

  assign mode_eff = (mode > lts_pkg::MODE_ATOM) ? lts_pkg::MODE_SKIP : mode;

  // skip mode handling, also used for an atom terminator
  always_comb begin
    skip_emit  = 1'b0;
    skip_mode  = lts_pkg::MODE_SKIP;
    skip_empty = string_empty;
    skip_res   = lts_pkg::make_res(lts_pkg::KIND_SYM, char_in, 1'b1, 1'b1, 1'b1);
    priority if (lts_pkg::is_space(char_in)) begin
      skip_mode = lts_pkg::MODE_SKIP;
    end else if (lts_pkg::is_single(char_in)) begin
      skip_emit = 1'b1;
    end else if (char_in == lts_pkg::CH_SEMI) begin
      skip_mode = lts_pkg::MODE_COMMENT;
    end else if (char_in == lts_pkg::CH_DQUOTE) begin
      skip_mode  = lts_pkg::MODE_STRING;
      skip_empty = 1'b1;
    end else begin
      skip_emit = 1'b1;
      skip_mode = lts_pkg::MODE_ATOM;
      skip_res  = lts_pkg::make_res(lts_pkg::KIND_SYM, char_in, 1'b1, 1'b1, 1'b0);
    end
  end

  always_comb begin
    dec.count      = 2'd0;
    dec.res0       = skip_res;
    dec.res1       = lts_pkg::make_res(lts_pkg::KIND_END, 8'h00, 1'b0, 1'b0, 1'b0);
    dec.mode_next  = mode_eff;
    dec.empty_next = string_empty;
    if (command == lts_pkg::CMD_END) begin
      dec.mode_next  = lts_pkg::MODE_SKIP;
      dec.empty_next = 1'b1;
      if (mode_eff == lts_pkg::MODE_STRING || mode_eff == lts_pkg::MODE_ESCAPE) begin
        dec.count = 2'd1;
        dec.res0  = lts_pkg::make_res(lts_pkg::KIND_ERR, 8'h00, 1'b0, string_empty,
                                      1'b1);
      end else if (mode_eff == lts_pkg::MODE_ATOM) begin
        dec.count = 2'd2;
        dec.res0  = lts_pkg::make_res(lts_pkg::KIND_SYM, 8'h00, 1'b0, 1'b0, 1'b1);
      end else begin
        dec.count = 2'd1;
        dec.res0  = lts_pkg::make_res(lts_pkg::KIND_END, 8'h00, 1'b0, 1'b0, 1'b0);
      end
    end else begin
      unique case (mode_eff)
        lts_pkg::MODE_COMMENT: begin
          if (char_in == lts_pkg::CH_LF) dec.mode_next = lts_pkg::MODE_SKIP;
        end
        lts_pkg::MODE_STRING: begin
          if (char_in == lts_pkg::CH_BSLASH) begin
            dec.mode_next = lts_pkg::MODE_ESCAPE;
          end else if (char_in == lts_pkg::CH_DQUOTE) begin
            dec.count      = 2'd1;
            dec.res0       = lts_pkg::make_res(lts_pkg::KIND_STR, 8'h00, string_empty,
                                               string_empty, 1'b1);
            dec.mode_next  = lts_pkg::MODE_SKIP;
            dec.empty_next = 1'b1;
          end else begin
            dec.count      = 2'd1;
            dec.res0       = lts_pkg::make_res(lts_pkg::KIND_STR, char_in, 1'b1,
                                               string_empty, 1'b0);
            dec.empty_next = 1'b0;
          end
        end
        lts_pkg::MODE_ESCAPE: begin
          dec.count      = 2'd1;
          dec.res0       = lts_pkg::make_res(lts_pkg::KIND_STR,
                                             (char_in == lts_pkg::CH_N) ?
                                             lts_pkg::CH_LF : char_in,
                                             1'b1, string_empty, 1'b0);
          dec.empty_next = 1'b0;
          dec.mode_next  = lts_pkg::MODE_STRING;
        end
        lts_pkg::MODE_ATOM: begin
          if (lts_pkg::ends_atom(char_in)) begin
            dec.count      = skip_emit ? 2'd2 : 2'd1;
            dec.res0       = lts_pkg::make_res(lts_pkg::KIND_SYM, 8'h00, 1'b0, 1'b0,
                                               1'b1);
            dec.res1       = skip_res;
            dec.mode_next  = skip_mode;
            dec.empty_next = skip_empty;
          end else begin
            dec.count = 2'd1;
            dec.res0  = lts_pkg::make_res(lts_pkg::KIND_SYM, char_in, 1'b1, 1'b0, 1'b0);
          end
        end
        default: begin
          dec.count      = skip_emit ? 2'd1 : 2'd0;
          dec.res0       = skip_res;
          dec.mode_next  = skip_mode;
          dec.empty_next = skip_empty;
        end
      endcase
    end
  end

endmodule

### rtl/lts_result_fifo.sv
// ----------------------------------------------------------------------------
// lts_result_fifo
// Small result queue: takes up to two results a cycle, hands out one when the receiver is ready.
// ----------------------------------------------------------------------------
module lts_result_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                        [1:0] push_count,
  input  lts_pkg::res_t                     push0,
  input  lts_pkg::res_t                     push1,
  output logic                              room2,
  output logic                              valid,
  input  logic                              ready,
  output lts_pkg::res_t                     head
);

  lts_pkg::res_t                    entries [lts_pkg::FIFO_DEPTH];
  logic [lts_pkg::PTR_W-1:0]        wptr;
  logic [lts_pkg::PTR_W-1:0]        rptr;
  logic [lts_pkg::CNT_W-1:0]        count;
  logic [lts_pkg::CNT_W-1:0]        count_next;
  logic                             pop;

  assign pop   = valid && ready;
  assign valid = count != '0;
  assign head  = entries[rptr];
  assign room2 = count <= lts_pkg::CNT_W'(lts_pkg::FIFO_DEPTH - 2);
  assign count_next = count + lts_pkg::CNT_W'(push_count) - lts_pkg::CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + lts_pkg::PTR_W'(push_count);
      rptr  <= rptr + lts_pkg::PTR_W'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wptr] <= push0;
    if (push_count == 2'd2) entries[wptr + lts_pkg::PTR_W'(1)] <= push1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= lts_pkg::CNT_W'(lts_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd0 |-> count <= lts_pkg::CNT_W'(lts_pkg::FIFO_DEPTH - 2) ||
                           (push_count == 2'd1 && pop))
    else $error("push into a full result queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    ##1 !$past(rst) |-> count == $past(count_next))
    else $error("result count mismatch");

endmodule

### rtl/lts_scanner_core.sv
// ----------------------------------------------------------------------------
// lts_scanner_core
// Scan state registers around the decode step.
// ----------------------------------------------------------------------------
module lts_scanner_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                command,
  input  logic          [7:0] char_in,
  output lts_pkg::dec_t       dec
);

  logic [2:0] mode;
  logic       string_empty;

  lts_decode u_decode (
    .mode         (mode),
    .string_empty (string_empty),
    .command      (command),
    .char_in      (char_in),
    .dec          (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= lts_pkg::MODE_SKIP;
      string_empty <= 1'b1;
    end else if (take) begin
      mode         <= dec.mode_next;
      string_empty <= dec.empty_next;
    end
  end

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    take && command == lts_pkg::CMD_END |=> mode == lts_pkg::MODE_SKIP && string_empty)
    else $error("end of source left scan state open");

  a_escape_from_string: assert property (@(posedge clk) disable iff (rst)
    mode == lts_pkg::MODE_ESCAPE |-> $past(mode) == lts_pkg::MODE_STRING ||
                                     $past(mode) == lts_pkg::MODE_ESCAPE)
    else $error("escape mode entered outside a string");

  a_nonempty_after_char: assert property (@(posedge clk) disable iff (rst)
    take && dec.count != 2'd0 && dec.res0.kind == lts_pkg::KIND_STR &&
    dec.res0.has_char && !dec.res0.token_last |=> !string_empty)
    else $error("string empty flag not cleared");

endmodule
